FILE: rtl/tkslpd_pkg.sv
// shared types, constants and register indexes of the two-key press detector
package tkslpd_pkg;

    localparam int TimeWidth  = 20;
    localparam int StepWidth  = 8;
    localparam int ShortWidth = 16;
    localparam int CodeWidth  = 2;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 20;

    localparam logic [CodeWidth-1:0] KeyOneCode = 2'd1;
    localparam logic [CodeWidth-1:0] KeyTwoCode = 2'd2;
    localparam logic [TimeWidth-1:0] TimeMax = {TimeWidth{1'b1}};

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_SCAN_STEP      = 3'd0,
        REG_SHORT_THR      = 3'd1,
        REG_KEY1_LONG_THR  = 3'd2,
        REG_KEY2_LONG_THR  = 3'd3,
        REG_EVENT_ENABLES  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CodeWidth-1:0] active_code;
        logic [CodeWidth-1:0] prev_code;
        logic [TimeWidth-1:0] hold;
        logic [TimeWidth-1:0] prev_hold;
    } key_state_t;

endpackage

FILE: rtl/tkslpd_hold_timer.sv
// key code and hold time tracking with saturating advance
module tkslpd_hold_timer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               step_en,
    input  logic [tkslpd_pkg::CodeWidth-1:0]   code,
    input  logic [tkslpd_pkg::StepWidth-1:0]   scan_step,
    output tkslpd_pkg::key_state_t             state_next,
    output tkslpd_pkg::key_state_t             state_cur
);
    import tkslpd_pkg::*;

    key_state_t           state_reg;
    logic [TimeWidth:0]   sum;
    logic [TimeWidth-1:0] advanced;

    always_comb begin
        sum = {1'b0, state_reg.hold} + {{(TimeWidth+1-StepWidth){1'b0}}, scan_step};
        advanced = sum[TimeWidth] ? TimeMax : sum[TimeWidth-1:0];
        state_next.prev_code = state_reg.active_code;
        if (code != state_reg.active_code) begin
            state_next.active_code = code;
            state_next.hold        = '0;
            state_next.prev_hold   = advanced;
        end else begin
            state_next.active_code = state_reg.active_code;
            state_next.hold        = advanced;
            state_next.prev_hold   = state_reg.hold;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

    assign state_cur = state_reg;

endmodule

FILE: rtl/tkslpd_judge.sv
// short and long press decision for one key
module tkslpd_judge (
    input  tkslpd_pkg::key_state_t                st,
    input  logic [tkslpd_pkg::CodeWidth-1:0]      match_code,
    input  logic [tkslpd_pkg::ShortWidth-1:0]     short_thr,
    input  logic [tkslpd_pkg::TimeWidth-1:0]      long_thr,
    input  logic                                  short_en,
    input  logic                                  long_en,
    output logic                                  short_ev,
    output logic                                  long_ev
);
    import tkslpd_pkg::*;

    logic [TimeWidth-1:0] short_ext;
    logic                 held;
    logic                 long_cross;
    logic                 short_cross;
    logic                 released_ok;

    always_comb begin
        short_ext   = {{(TimeWidth-ShortWidth){1'b0}}, short_thr};
        held        = (st.active_code == match_code);
        long_cross  = held && (st.hold >= long_thr) && (st.prev_hold < long_thr);
        short_cross = held && (st.hold >= short_ext) && (st.prev_hold < short_ext);
        released_ok = (st.prev_code == match_code) && !held &&
                      (st.prev_hold >= short_ext) && (st.prev_hold < long_thr);
        if (long_en) begin
            long_ev  = long_cross;
            short_ev = short_en && released_ok;
        end else begin
            long_ev  = 1'b0;
            short_ev = short_en && short_cross;
        end
    end

endmodule

FILE: rtl/two_key_short_long_press_detector_core.sv
// top level of the two-key short and long press detector
//
// one request on the s_ channel is one scan tick carrying both raw key levels
// (active low); each tick yields exactly one result on the m_ channel with the
// four event flags for that tick
// a request accepted into the input register is judged against the key state as it
// moves on into the result register, which drives m_tvalid
// throughput is one tick per cycle while the receiver does not stall, set by the hold time update
// (one 20-bit add with saturation and a handful of 20-bit compares)
// when the receiver stalls the result register holds and the input register
// keeps the next request; s_tready drops once both are full
// configuration goes through cfg_we, cfg_index and cfg_wdata, to be written by the
// user only while idle, which the block does not enforce; unknown indexes are ignored
// reset (aresetn low, synchronous) empties both registers, clears key codes and
// hold times and loads the default thresholds, step and enables
module two_key_short_long_press_detector_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [7:0]                             s_tdata,  // key1_level, key2_level
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [7:0]                             m_tdata,  // key1_short_event, key1_long_event,
                                                             // key2_short_event, key2_long_event
    input  logic                                   cfg_we,
    input  logic [tkslpd_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [tkslpd_pkg::CfgDataWidth-1:0]    cfg_wdata
);
    import tkslpd_pkg::*;

    logic [StepWidth-1:0]  scan_step_reg;
    logic [ShortWidth-1:0] short_thr_reg;
    logic [TimeWidth-1:0]  key1_long_reg;
    logic [TimeWidth-1:0]  key2_long_reg;
    logic [3:0]            enables_reg;

    logic                  in_valid_reg;
    logic [1:0]            levels_reg;
    logic                  out_valid_reg;
    logic [3:0]            events_reg;
    logic [3:0]            events_next;

    logic                  advance;
    logic                  fire;
    logic [CodeWidth-1:0]  code;
    key_state_t            state_next;
    key_state_t            state_cur;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_step_reg <= StepWidth'(10);
            short_thr_reg <= ShortWidth'(50);
            key1_long_reg <= TimeWidth'(3000);
            key2_long_reg <= TimeWidth'(3000);
            enables_reg   <= 4'hf;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SCAN_STEP:     scan_step_reg <= cfg_wdata[StepWidth-1:0];
                REG_SHORT_THR:     short_thr_reg <= cfg_wdata[ShortWidth-1:0];
                REG_KEY1_LONG_THR: key1_long_reg <= cfg_wdata[TimeWidth-1:0];
                REG_KEY2_LONG_THR: key2_long_reg <= cfg_wdata[TimeWidth-1:0];
                REG_EVENT_ENABLES: enables_reg   <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            levels_reg <= s_tdata[1:0];
        end
    end

    assign code = ~levels_reg;

    tkslpd_hold_timer u_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (fire),
        .code       (code),
        .scan_step  (scan_step_reg),
        .state_next (state_next),
        .state_cur  (state_cur)
    );

    tkslpd_judge u_judge_key1 (
        .st         (state_next),
        .match_code (KeyOneCode),
        .short_thr  (short_thr_reg),
        .long_thr   (key1_long_reg),
        .short_en   (enables_reg[0]),
        .long_en    (enables_reg[1]),
        .short_ev   (events_next[0]),
        .long_ev    (events_next[1])
    );

    tkslpd_judge u_judge_key2 (
        .st         (state_next),
        .match_code (KeyTwoCode),
        .short_thr  (short_thr_reg),
        .long_thr   (key2_long_reg),
        .short_en   (enables_reg[2]),
        .long_en    (enables_reg[3]),
        .short_ev   (events_next[2]),
        .long_ev    (events_next[3])
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            events_reg <= events_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, events_reg};

`ifndef SYNTHESIS
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(state_cur))
        else $error("key state changed without a tick");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (code != state_cur.active_code)) |=> (state_cur.hold == '0))
        else $error("hold time not restarted on code change");

    a_key1_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("key one short and long event together");

    a_key2_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
        else $error("key two short and long event together");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// testbench for the two-key short and long press detector core
module tb_top;
    import tkslpd_pkg::*;

    localparam logic [CfgIdxWidth-1:0] RegNoSuch    = 3'd7;
    localparam logic [CodeWidth-1:0]   NoKeyCode    = 2'd0;
    localparam logic [CodeWidth-1:0]   BothKeysCode = 2'd3;
    localparam int RandomPhases = 8;
    localparam int PhaseTicks   = 200;
    localparam int DrillRows    = 32;

    typedef struct packed {
        logic key2_long;
        logic key2_short;
        logic key1_long;
        logic key1_short;
    } press_events_t;

    typedef struct {
        logic                    cfg;
        logic [CfgIdxWidth-1:0]  idx;
        logic [CfgDataWidth-1:0] val;
        logic                    k1;
        logic                    k2;
        int                      reps;
        logic                    chk;
        press_events_t           ev;
    } drill_row_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic                    cfg_we    = 1'b0;
    logic [CfgIdxWidth-1:0]  cfg_index = '0;
    logic [CfgDataWidth-1:0] cfg_wdata = '0;

    // local copy of the key state and registers
    logic [CodeWidth-1:0]  code_now  = '0;
    logic [CodeWidth-1:0]  code_last = '0;
    logic [TimeWidth-1:0]  held_ms   = '0;
    logic [TimeWidth-1:0]  held_last = '0;
    logic [StepWidth-1:0]  step_ms   = 8'd10;
    logic [ShortWidth-1:0] short_ms  = 16'd50;
    logic [TimeWidth-1:0]  long1_ms  = 20'd3000;
    logic [TimeWidth-1:0]  long2_ms  = 20'd3000;
    logic [3:0]            enables   = 4'hF;

    press_events_t pending_events[$];
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int failures        = 0;
    int ticks_sent      = 0;
    int results_checked = 0;
    int flags_seen      = 0;
    int settings_used   = 0;

    string flag_names [4] = '{"key1_short_event", "key1_long_event",
                              "key2_short_event", "key2_long_event"};

    drill_row_t drill [DrillRows] = '{
        '{1'b1, REG_SCAN_STEP,     20'd255,  1'b1, 1'b1, 0, 1'b0, 4'b0000},
        '{1'b1, REG_SHORT_THR,     20'd500,  1'b1, 1'b1, 0, 1'b0, 4'b0000},
        '{1'b1, REG_KEY1_LONG_THR, 20'd1000, 1'b1, 1'b1, 0, 1'b0, 4'b0000},
        '{1'b1, REG_KEY2_LONG_THR, 20'd1500, 1'b1, 1'b1, 0, 1'b0, 4'b0000},
        '{1'b1, REG_EVENT_ENABLES, 20'hF,    1'b1, 1'b1, 0, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b1, 1'b1, 1, 1'b1, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b0, 1'b1, 3, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b1, 1'b1, 1, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b0, 1'b1, 6, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b1, 1'b1, 1, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b1, 1'b0, 4, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b0, 1'b0, 2, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b0, 1'b1, 1, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b1, 1'b0, 8, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b1, 1'b1, 1, 1'b0, 4'b0000},
        '{1'b1, REG_EVENT_ENABLES, 20'h5,    1'b1, 1'b1, 0, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b0, 1'b1, 4, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b1, 1'b0, 4, 1'b0, 4'b0000},
        '{1'b1, REG_EVENT_ENABLES, 20'h0,    1'b1, 1'b1, 0, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b0, 1'b1, 4, 1'b1, 4'b0000},
        '{1'b1, REG_SCAN_STEP,     20'd0,    1'b1, 1'b1, 0, 1'b0, 4'b0000},
        '{1'b1, REG_SHORT_THR,     20'd0,    1'b1, 1'b1, 0, 1'b0, 4'b0000},
        '{1'b1, REG_EVENT_ENABLES, 20'hF,    1'b1, 1'b1, 0, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b1, 1'b0, 4, 1'b0, 4'b0000},
        '{1'b1, REG_SCAN_STEP,     20'hFFF01, 1'b1, 1'b1, 0, 1'b0, 4'b0000},
        '{1'b1, REG_SHORT_THR,     20'd65535, 1'b1, 1'b1, 0, 1'b0, 4'b0000},
        '{1'b1, REG_KEY1_LONG_THR, 20'd0,    1'b1, 1'b1, 0, 1'b0, 4'b0000},
        '{1'b1, REG_KEY2_LONG_THR, TimeMax,  1'b1, 1'b1, 0, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b0, 1'b1, 3, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b1, 1'b1, 1, 1'b0, 4'b0000},
        '{1'b1, RegNoSuch,         TimeMax,  1'b1, 1'b1, 0, 1'b0, 4'b0000},
        '{1'b0, REG_SCAN_STEP,     20'd0,    1'b1, 1'b1, 1, 1'b1, 4'b0000}
    };

    two_key_short_long_press_detector_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic hold_crossed(logic [CodeWidth-1:0] key, logic [TimeWidth-1:0] thr);
        return code_now == key && held_ms >= thr && held_last < thr;
    endfunction

    // returns {long, short} for one key
    function automatic logic [1:0] judge_key(logic [CodeWidth-1:0] key,
                                             logic [TimeWidth-1:0] long_thr,
                                             logic short_en, logic long_en);
        logic lng;
        logic sht;
        lng = 1'b0;
        sht = 1'b0;
        if (long_en) begin
            lng = hold_crossed(key, long_thr);
            sht = short_en && code_last == key && code_now != key &&
                  held_last >= short_ms && held_last < long_thr;
        end else if (short_en) begin
            sht = hold_crossed(key, TimeWidth'(short_ms));
        end
        return {lng, sht};
    endfunction

    task automatic judge_scan_tick(input logic k1, input logic k2, output press_events_t ev);
        logic [CodeWidth-1:0] code;
        logic [TimeWidth:0]   sum;
        logic [TimeWidth-1:0] adv;
        code = {~k2, ~k1};
        sum = {1'b0, held_ms} + step_ms;
        adv = (sum > {1'b0, TimeMax}) ? TimeMax : sum[TimeWidth-1:0];
        code_last = code_now;
        if (code != code_now) begin
            held_last = adv;
            code_now  = code;
            held_ms   = '0;
        end else begin
            held_last = held_ms;
            held_ms   = adv;
        end
        {ev.key1_long, ev.key1_short} = judge_key(KeyOneCode, long1_ms, enables[0], enables[1]);
        {ev.key2_long, ev.key2_short} = judge_key(KeyTwoCode, long2_ms, enables[2], enables[3]);
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgDataWidth-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_SCAN_STEP:     step_ms  = val[StepWidth-1:0];
            REG_SHORT_THR:     short_ms = val[ShortWidth-1:0];
            REG_KEY1_LONG_THR: long1_ms = val;
            REG_KEY2_LONG_THR: long2_ms = val;
            REG_EVENT_ENABLES: enables  = val[3:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic configure(input logic [7:0] st, input logic [15:0] sh,
                             input logic [19:0] l1, input logic [19:0] l2, input logic [3:0] en);
        write_reg(REG_SCAN_STEP, {12'hFFF, st});
        write_reg(REG_SHORT_THR, {4'hA, sh});
        write_reg(REG_KEY1_LONG_THR, l1);
        write_reg(REG_KEY2_LONG_THR, l2);
        write_reg(REG_EVENT_ENABLES, {16'h5A5A, en});
        write_reg(RegNoSuch, CfgDataWidth'($urandom));
        end_writes();
    endtask

    // lets every outstanding result drain before the registers change
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_tick(input logic k1, input logic k2, input logic chk,
                             input press_events_t typed);
        press_events_t ev;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, k2, k1};
        do @(posedge aclk); while (!s_tready);
        judge_scan_tick(k1, k2, ev);
        pending_events.push_back(chk ? typed : ev);
        ticks_sent++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
        endcase
    endtask

    task automatic run_random_phase(input int p);
        logic [7:0]  st;
        logic [15:0] sh;
        logic [19:0] l1;
        logic [19:0] l2;
        logic [19:0] thr;
        logic [3:0]  en;
        logic [CodeWidth-1:0] code;
        int span;
        int n;
        int r;
        int sent;
        settle();
        set_idling(p % 4);
        case (p)
            0: begin st = 8'd10;  sh = 16'd50;    l1 = 20'd120; l2 = 20'd200; en = 4'hF; end
            1: begin st = 8'd255; sh = 16'd65535; l1 = 20'd0;   l2 = TimeMax; en = 4'hF; end
            2: begin st = 8'd1;   sh = 16'd0;     l1 = 20'd5;   l2 = 20'd9;   en = 4'hA; end
            default: begin
                st = 8'($urandom_range(255, 1));
                sh = 16'($urandom_range(st * 6));
                l1 = 20'(sh + st * $urandom_range(10) + $urandom_range(st));
                l2 = 20'(sh + st * $urandom_range(10) + $urandom_range(st));
                en = 4'($urandom_range(15));
            end
        endcase
        configure(st, sh, l1, l2, en);
        thr = (l1 > l2) ? l1 : l2;
        if (sh > thr) thr = sh;
        span = (st == 0) ? 6 : int'(thr / st) + 3;
        if (span > 40) span = 40;
        sent = 0;
        while (sent < PhaseTicks) begin
            r = $urandom_range(99);
            if (r < 15) begin
                send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
                sent++;
            end else begin
                code = (r < 55) ? KeyOneCode : (r < 90) ? KeyTwoCode :
                       (r < 95) ? BothKeysCode : NoKeyCode;
                n = $urandom_range(span, 1);
                repeat (n) send_tick(~code[0], ~code[1], 1'b0, '0);
                sent += n;
            end
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        press_events_t want;
        press_events_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[3:0];
            if (pending_events.size() == 0) begin
                $error("result %b with no request outstanding", got);
                failures++;
            end else begin
                want = pending_events.pop_front();
                results_checked++;
                flags_seen += $countones(got);
                for (int i = 0; i < 4; i++) begin
                    if (want[i] !== got[i]) begin
                        $error("%s: expected %0b, got %0b", flag_names[i], want[i], got[i]);
                        failures++;
                    end
                end
            end
        end
    end

    initial begin
        bit cfg_open;
        cfg_open = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (drill[i]) begin
            if (drill[i].cfg) begin
                if (!cfg_open) settle();
                write_reg(drill[i].idx, drill[i].val);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) end_writes();
                cfg_open = 1'b0;
                repeat (drill[i].reps) send_tick(drill[i].k1, drill[i].k2, drill[i].chk, drill[i].ev);
            end
        end

        for (int p = 0; p < RandomPhases; p++) run_random_phase(p);
        settle();

        $display("%0d scan ticks sent, %0d results checked, %0d event flags raised",
                 ticks_sent, results_checked, flags_seen);
        $display("%0d register settings across directed and random phases, all four idling modes",
                 settings_used);
        if (failures == 0) begin
            $display("two_key_short_long_press_detector_core regression: pass");
        end else begin
            $display("two_key_short_long_press_detector_core regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("two_key_short_long_press_detector_core regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tkslpd_pkg.sv
rtl/tkslpd_hold_timer.sv
rtl/tkslpd_judge.sv
rtl/two_key_short_long_press_detector_core.sv
tb/tb_top.sv
